// ----- rtl/dcfe_pkg.sv -----
// Shared types, codes and format decode for the fast-clear element generator.
`default_nettype none
package dcfe_pkg;

  localparam logic [2:0] MODE_UNCOMPRESSED = 3'd0;
  localparam logic [2:0] MODE_C0000        = 3'd1;
  localparam logic [2:0] MODE_C0001        = 3'd2;
  localparam logic [2:0] MODE_C1110        = 3'd3;
  localparam logic [2:0] MODE_C1111        = 3'd4;
  localparam logic [2:0] MODE_REGISTER     = 3'd5;
  localparam logic [2:0] MODE_MIXED        = 3'd6;
  localparam logic [2:0] MODE_UNREADABLE   = 3'd7;

  localparam logic [2:0] KIND_UNORM = 3'd0;
  localparam logic [2:0] KIND_SNORM = 3'd1;
  localparam logic [2:0] KIND_UINT  = 3'd2;
  localparam logic [2:0] KIND_SINT  = 3'd3;
  localparam logic [2:0] KIND_FLOAT = 3'd4;

  // Channel layout classes.
  localparam logic [1:0] WCLS_8        = 2'd0;
  localparam logic [1:0] WCLS_16       = 2'd1;
  localparam logic [1:0] WCLS_32       = 2'd2;
  localparam logic [1:0] WCLS_10_10_10_2 = 2'd3;

  localparam logic [31:0] HALF_ONE   = 32'h0000_3c00;
  localparam logic [31:0] SINGLE_ONE = 32'h3f80_0000;

  typedef struct packed {
    logic       valid;
    logic [2:0] nch;
    logic [1:0] wcls;
    logic [2:0] kind;
  } shape_t;

  typedef struct packed {
    logic         ok;
    logic [4:0]   nbytes;
    logic         two;
    logic [127:0] data;
  } texel_t;

  function automatic shape_t mk(input logic [2:0] nch, input logic [1:0] wcls,
                                input logic [2:0] kind);
    shape_t s;
    s.valid = 1'b1;
    s.nch   = nch;
    s.wcls  = wcls;
    s.kind  = kind;
    return s;
  endfunction

  function automatic shape_t shape_of(input logic [7:0] code);
    shape_t s;
    s = '0;
    case (code)
      8'd9, 8'd15:                s = mk(3'd1, WCLS_8, KIND_UNORM);
      8'd13:                      s = mk(3'd1, WCLS_8, KIND_UINT);
      8'd70:                      s = mk(3'd1, WCLS_16, KIND_UNORM);
      8'd71:                      s = mk(3'd1, WCLS_16, KIND_SNORM);
      8'd74:                      s = mk(3'd1, WCLS_16, KIND_UINT);
      8'd75:                      s = mk(3'd1, WCLS_16, KIND_SINT);
      8'd76:                      s = mk(3'd1, WCLS_16, KIND_FLOAT);
      8'd16, 8'd22:               s = mk(3'd2, WCLS_8, KIND_UNORM);
      8'd17:                      s = mk(3'd2, WCLS_8, KIND_SNORM);
      8'd20:                      s = mk(3'd2, WCLS_8, KIND_UINT);
      8'd21:                      s = mk(3'd2, WCLS_8, KIND_SINT);
      8'd98:                      s = mk(3'd1, WCLS_32, KIND_UINT);
      8'd99:                      s = mk(3'd1, WCLS_32, KIND_SINT);
      8'd100:                     s = mk(3'd1, WCLS_32, KIND_FLOAT);
      8'd77:                      s = mk(3'd2, WCLS_16, KIND_UNORM);
      8'd78:                      s = mk(3'd2, WCLS_16, KIND_SNORM);
      8'd81:                      s = mk(3'd2, WCLS_16, KIND_UINT);
      8'd82:                      s = mk(3'd2, WCLS_16, KIND_SINT);
      8'd83:                      s = mk(3'd2, WCLS_16, KIND_FLOAT);
      8'd64:                      s = mk(3'd4, WCLS_10_10_10_2, KIND_UNORM);
      8'd68:                      s = mk(3'd4, WCLS_10_10_10_2, KIND_UINT);
      8'd37, 8'd43, 8'd44, 8'd50: s = mk(3'd4, WCLS_8, KIND_UNORM);
      8'd38:                      s = mk(3'd4, WCLS_8, KIND_SNORM);
      8'd41:                      s = mk(3'd4, WCLS_8, KIND_UINT);
      8'd42:                      s = mk(3'd4, WCLS_8, KIND_SINT);
      8'd101:                     s = mk(3'd2, WCLS_32, KIND_UINT);
      8'd102:                     s = mk(3'd2, WCLS_32, KIND_SINT);
      8'd103:                     s = mk(3'd2, WCLS_32, KIND_FLOAT);
      8'd91:                      s = mk(3'd4, WCLS_16, KIND_UNORM);
      8'd92:                      s = mk(3'd4, WCLS_16, KIND_SNORM);
      8'd95:                      s = mk(3'd4, WCLS_16, KIND_UINT);
      8'd96:                      s = mk(3'd4, WCLS_16, KIND_SINT);
      8'd97:                      s = mk(3'd4, WCLS_16, KIND_FLOAT);
      8'd107:                     s = mk(3'd4, WCLS_32, KIND_UINT);
      8'd108:                     s = mk(3'd4, WCLS_32, KIND_SINT);
      8'd109:                     s = mk(3'd4, WCLS_32, KIND_FLOAT);
      default:                    s = '0;
    endcase
    return s;
  endfunction

  // The value "one" for a channel of the given kind and bit width.
  function automatic logic [31:0] unit_value(input logic [2:0] kind, input logic [5:0] w);
    logic [31:0] m;
    logic [31:0] v;
    case (w)
      6'd2:    m = 32'h0000_0003;
      6'd8:    m = 32'h0000_00ff;
      6'd10:   m = 32'h0000_03ff;
      6'd16:   m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    case (kind)
      KIND_UNORM, KIND_UINT: v = m;
      KIND_SNORM, KIND_SINT: v = m >> 1;
      default:               v = (w == 6'd16) ? HALF_ONE : SINGLE_ONE;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/dcfe_req_if.sv -----
// Request channel: format, clear code and alpha placement.
`default_nettype none
interface dcfe_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] format_code;
  logic [2:0] mode;
  logic       alpha_on_msb;

  modport source (output valid, output format_code, output mode, output alpha_on_msb,
                  input ready);
  modport sink (input valid, input format_code, input mode, input alpha_on_msb,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/dcfe_rsp_if.sv -----
// Response channel: one 64-bit word of the cleared texel.
`default_nettype none
interface dcfe_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [4:0]  element_bytes;
  logic        word_index;
  logic [63:0] element_word;
  logic        last;

  modport source (output valid, output ok, output element_bytes, output word_index,
                  output element_word, output last, input ready);
  modport sink (input valid, input ok, input element_bytes, input word_index,
                input element_word, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/dcfe_build.sv -----
// Combinational texel builder: decodes the format and packs the clear value.
`default_nettype none
module dcfe_build (
  input  logic [7:0]        format_code,
  input  logic [2:0]        mode,
  input  logic              alpha_on_msb,
  output dcfe_pkg::texel_t  texel
);

  dcfe_pkg::shape_t shape;
  logic             color_set;
  logic             alpha_set;
  logic [1:0]       alpha_ch;
  logic [31:0]      v [4];
  logic [5:0]       w [4];
  logic             usable;

  always_comb begin
    shape     = dcfe_pkg::shape_of(format_code);
    color_set = (mode == dcfe_pkg::MODE_C1110) || (mode == dcfe_pkg::MODE_C1111);
    alpha_set = (mode == dcfe_pkg::MODE_C0001) || (mode == dcfe_pkg::MODE_C1111);
    alpha_ch  = alpha_on_msb ? 2'(shape.nch - 3'd1) : 2'd0;
    usable    = shape.valid && ((mode == dcfe_pkg::MODE_C0001) ||
                                (mode == dcfe_pkg::MODE_C1110) ||
                                (mode == dcfe_pkg::MODE_C1111));

    for (int ch = 0; ch < 4; ch++) begin
      case (shape.wcls)
        dcfe_pkg::WCLS_8:  w[ch] = 6'd8;
        dcfe_pkg::WCLS_16: w[ch] = 6'd16;
        dcfe_pkg::WCLS_32: w[ch] = 6'd32;
        default:           w[ch] = (ch == 3) ? 6'd2 : 6'd10;
      endcase
      if (3'(ch) >= shape.nch) begin
        v[ch] = '0;
      end else if (((2'(ch) == alpha_ch) ? alpha_set : color_set)) begin
        v[ch] = dcfe_pkg::unit_value(shape.kind, w[ch]);
      end else begin
        v[ch] = '0;
      end
    end

    texel = '0;
    if (mode == dcfe_pkg::MODE_C0000) begin
      texel.ok     = 1'b1;
      texel.nbytes = 5'd1;
    end else if (usable) begin
      texel.ok = 1'b1;
      case (shape.wcls)
        dcfe_pkg::WCLS_8: begin
          texel.data   = {96'b0, v[3][7:0], v[2][7:0], v[1][7:0], v[0][7:0]};
          texel.nbytes = {2'b0, shape.nch};
        end
        dcfe_pkg::WCLS_16: begin
          texel.data   = {64'b0, v[3][15:0], v[2][15:0], v[1][15:0], v[0][15:0]};
          texel.nbytes = {1'b0, shape.nch, 1'b0};
        end
        dcfe_pkg::WCLS_32: begin
          texel.data   = {v[3], v[2], v[1], v[0]};
          texel.nbytes = {shape.nch, 2'b0};
        end
        default: begin
          texel.data   = {96'b0, v[3][1:0], v[2][9:0], v[1][9:0], v[0][9:0]};
          texel.nbytes = 5'd4;
        end
      endcase
      texel.two = (texel.nbytes > 5'd8);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dcfe_emit.sv -----
// Result register and word sequencer: holds one texel and sends it word by word.
`default_nettype none
module dcfe_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  output logic              load_ready,
  input  dcfe_pkg::texel_t  texel,
  dcfe_rsp_if.source        rsp
);

  dcfe_pkg::texel_t held;
  logic             full;
  logic             ptr;
  logic             last_word;
  logic             done;

  assign last_word  = !held.two || ptr;
  assign done       = full && rsp.ready && last_word;
  assign load_ready = !full || done;

  assign rsp.valid         = full;
  assign rsp.ok            = held.ok;
  assign rsp.element_bytes = held.nbytes;
  assign rsp.word_index    = ptr;
  assign rsp.element_word  = ptr ? held.data[127:64] : held.data[63:0];
  assign rsp.last          = last_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      ptr  <= 1'b0;
    end else if (load_valid && load_ready) begin
      full <= 1'b1;
      ptr  <= 1'b0;
    end else if (done) begin
      full <= 1'b0;
      ptr  <= 1'b0;
    end else if (full && rsp.ready) begin
      ptr <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      held <= texel;
    end
  end

  // The second word is only ever pointed at for a sixteen-byte texel.
  assert property (@(posedge clk) disable iff (rst) (full && ptr) |-> held.two)
    else $error("second word selected for a single-word texel");

  // After the first word of a two-word texel goes out, the second follows.
  assert property (@(posedge clk) disable iff (rst)
                   (full && rsp.ready && !last_word) |=> (full && ptr))
    else $error("second word lost after first word handshake");

  // A failed request carries no byte count.
  assert property (@(posedge clk) disable iff (rst)
                   (full && !held.ok) |-> (held.nbytes == 5'd0 && !held.two))
    else $error("failed request reports texel bytes");

  // A new texel always starts at its first word.
  assert property (@(posedge clk) disable iff (rst)
                   (load_valid && load_ready) |=> !ptr)
    else $error("new texel not started at word zero");

endmodule
`default_nettype wire

// ----- rtl/dcc_fast_clear_element_gen.sv -----
// Top level of the fast-clear element generator.
`default_nettype none
// Usage:
// A request word on req carries a format number, a clear code and the alpha
// placement flag. For each request the block returns one or two words on
// rsp, each a 64-bit slice of the packed clear texel, with the last word
// flagged. Sixteen-byte texels give two words, everything else gives one;
// clear code 0000 gives a single zero byte whatever the format; otherwise an
// unknown format or a non-fast-clear code gives one word with ok low.
// A request is registered in the input register, decoded and packed
// combinationally, and loaded into the result register once that can take
// it; its first word is then presented on rsp.
// Throughput: one response word per cycle while rsp.ready is high. A texel
// occupies the result register until its last word is taken; the result
// register is what limits the rate. The input register can take one new
// request while a finished texel waits in the result register.
// Reset (rst, synchronous) empties both registers; no response is pending.
// When the receiver holds rsp.ready low, the current word stays on rsp and
// at most one further request is held in the input register, after which
// req.ready goes low.
module dcc_fast_clear_element_gen (
  input  logic       clk,
  input  logic       rst,
  dcfe_req_if.sink   req,
  dcfe_rsp_if.source rsp
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_format_code;
  logic [2:0] s1_mode;
  logic       s1_alpha_on_msb;

  dcfe_pkg::texel_t texel;
  logic             emit_ready;

  // The input register drains into the result register whenever that one
  // can take a new texel, so a request is accepted in the same cycle.
  assign req.ready = !s1_valid || emit_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (emit_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_format_code  <= req.format_code;
      s1_mode         <= req.mode;
      s1_alpha_on_msb <= req.alpha_on_msb;
    end
  end

  // Format decode and texel packing between the two registers.
  dcfe_build u_build (
    .format_code  (s1_format_code),
    .mode         (s1_mode),
    .alpha_on_msb (s1_alpha_on_msb),
    .texel        (texel)
  );

  // Result register and word sequencing onto rsp.
  dcfe_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s1_valid),
    .load_ready (emit_ready),
    .texel      (texel),
    .rsp        (rsp)
  );

endmodule
`default_nettype wire
